@@ rtl/core/scancode_set1_decoder_fifo_top_defines.svh @@
// ----------------------------------------------------------------------------
// Scancode decoder assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_DECODER_FIFO_TOP_DEFINES_SVH
`define SCANCODE_SET1_DECODER_FIFO_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define SCDF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/scdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder package
// Constants and types shared by the decoder blocks, and the ASCII tables.
// ----------------------------------------------------------------------------
package scdf_pkg;

    localparam int QueueDepth = 256;
    localparam int PtrW       = $clog2(QueueDepth);
    localparam int RomSize    = 59;
    localparam int RomIdxW    = $clog2(RomSize);

    typedef logic [7:0]      t_byte;
    typedef logic [PtrW-1:0] t_ptr;
    typedef logic [7:0]      t_cfg_idx;

    localparam logic ReqByte = 1'b0;
    localparam logic ReqRead = 1'b1;

    localparam t_cfg_idx CfgIdxUp    = 8'd0;
    localparam t_cfg_idx CfgIdxDown  = 8'd1;
    localparam t_cfg_idx CfgIdxLeft  = 8'd2;
    localparam t_cfg_idx CfgIdxRight = 8'd3;

    localparam t_byte CodeUpRst    = 8'd128;
    localparam t_byte CodeDownRst  = 8'd129;
    localparam t_byte CodeLeftRst  = 8'd130;
    localparam t_byte CodeRightRst = 8'd131;

    localparam t_byte ScExtPrefix  = 8'hE0;
    localparam t_byte ScLShiftMake = 8'h2A;
    localparam t_byte ScRShiftMake = 8'h36;
    localparam t_byte ScLShiftBrk  = 8'hAA;
    localparam t_byte ScRShiftBrk  = 8'hB6;
    localparam t_byte ScUp         = 8'h48;
    localparam t_byte ScDown       = 8'h50;
    localparam t_byte ScLeft       = 8'h4B;
    localparam t_byte ScRight      = 8'h4D;

    localparam t_byte PlainRom [0:RomSize-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    localparam t_byte ShiftRom [0:RomSize-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    typedef struct packed {
        logic  valid;
        t_byte code;
    } t_push;

    function automatic t_ptr ptr_next(input t_ptr p);
        return (p == t_ptr'(QueueDepth - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ rtl/core/scdf_if.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scdf_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] scan_byte;

    modport source (output valid, output req_type, output scan_byte, input ready);
    modport sink   (input valid, input req_type, input scan_byte, output ready);
endinterface

interface scdf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       queue_empty;

    modport source (output valid, output key_code, output queue_empty, input ready);
    modport sink   (input valid, input key_code, input queue_empty, output ready);
endinterface

interface scdf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/scdf_decode.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder front end
// Tracks prefix and shift state, holds the arrow code registers and turns
// each scan byte into at most one queue write.
// ----------------------------------------------------------------------------
module scdf_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scdf_cfg_if.sink        i_cfg,
    input  logic            i_byte_valid,
    input  scdf_pkg::t_byte i_scan_byte,
    output scdf_pkg::t_push o_push
);
    import scdf_pkg::*;

    t_byte r_code_up;
    t_byte r_code_down;
    t_byte r_code_left;
    t_byte r_code_right;
    logic  r_shift_held;
    logic  r_prefix_seen;

    logic  cfg_fire;
    logic  is_prefix;
    logic  is_shift_make;
    logic  is_shift_brk;
    logic  is_release;
    logic  in_rom;
    t_byte rom_code;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_up    <= CodeUpRst;
            r_code_down  <= CodeDownRst;
            r_code_left  <= CodeLeftRst;
            r_code_right <= CodeRightRst;
        end else if (cfg_fire) begin
            if (i_cfg.index == CfgIdxUp)    r_code_up    <= i_cfg.data;
            if (i_cfg.index == CfgIdxDown)  r_code_down  <= i_cfg.data;
            if (i_cfg.index == CfgIdxLeft)  r_code_left  <= i_cfg.data;
            if (i_cfg.index == CfgIdxRight) r_code_right <= i_cfg.data;
        end
    end

    assign is_prefix     = (i_scan_byte == ScExtPrefix);
    assign is_shift_make = (i_scan_byte == ScLShiftMake) || (i_scan_byte == ScRShiftMake);
    assign is_shift_brk  = (i_scan_byte == ScLShiftBrk) || (i_scan_byte == ScRShiftBrk);
    assign is_release    = i_scan_byte[7];
    assign in_rom        = (i_scan_byte < t_byte'(RomSize));
    assign rom_code      = r_shift_held ? ShiftRom[i_scan_byte[RomIdxW-1:0]]
                                        : PlainRom[i_scan_byte[RomIdxW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held  <= 1'b0;
            r_prefix_seen <= 1'b0;
        end else if (i_byte_valid) begin
            priority if (is_prefix) begin
                r_prefix_seen <= 1'b1;
            end else if (r_prefix_seen) begin
                r_prefix_seen <= 1'b0;
            end else if (is_shift_make) begin
                r_shift_held <= 1'b1;
            end else if (is_shift_brk) begin
                r_shift_held <= 1'b0;
            end else begin
                r_shift_held <= r_shift_held;
            end
        end
    end

    always_comb begin
        o_push = '0;
        if (i_byte_valid && !is_prefix) begin
            if (r_prefix_seen) begin
                if (!is_release) begin
                    o_push.valid = 1'b1;
                    priority if (i_scan_byte == ScUp)    o_push.code = r_code_up;
                    else if (i_scan_byte == ScDown)      o_push.code = r_code_down;
                    else if (i_scan_byte == ScLeft)      o_push.code = r_code_left;
                    else if (i_scan_byte == ScRight)     o_push.code = r_code_right;
                    else                                 o_push.valid = 1'b0;
                end
            end else if (!is_release && !is_shift_make && in_rom) begin
                o_push.code  = rom_code;
                o_push.valid = (rom_code != '0);
            end
        end
    end

endmodule

@@ rtl/core/scdf_queue.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder code queue
// Ring buffer in a synchronous memory with registered read data; a write
// into a full ring is dropped.
// ----------------------------------------------------------------------------
`include "scancode_set1_decoder_fifo_top_defines.svh"

module scdf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scdf_pkg::t_push i_push,
    input  logic            i_rd_req,
    output logic            o_empty,
    output scdf_pkg::t_byte o_rd_data
);
    import scdf_pkg::*;

    t_byte r_mem [0:QueueDepth-1];
    t_ptr  r_wr_ptr;
    t_ptr  r_rd_ptr;
    t_byte r_rd_data;

    t_ptr  wr_next;
    logic  full;
    logic  wr_en;
    logic  rd_en;

    assign wr_next = ptr_next(r_wr_ptr);
    assign full    = (wr_next == r_rd_ptr);
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign wr_en   = i_push.valid && !full;
    assign rd_en   = i_rd_req && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_push.code;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= wr_next;
            if (rd_en) r_rd_ptr <= ptr_next(r_rd_ptr);
        end
    end

    assign o_rd_data = r_rd_data;

    `SCDF_ASSERT_NEXT(a_full_drop, i_push.valid && full, $stable(r_wr_ptr), "write pointer moved while full")
    `SCDF_ASSERT_NEXT(a_empty_hold, i_rd_req && o_empty, $stable(r_rd_ptr), "read pointer moved while empty")
    `SCDF_ASSERT_SAME(a_one_access, i_push.valid, !i_rd_req, "queue write and read in one cycle")

endmodule

@@ rtl/core/scancode_set1_decoder_fifo_top.sv @@
// A read response is staged through the s1 register and then the output register.
// Throughput: one request per cycle while the response output is not stalled.
// Scan byte requests produce no response and retire in the cycle they are accepted.
// Reset clears pointers, shift and prefix flags, and restores the arrow codes.
// The code memory is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
// Scancode set 1 decoder with code queue, top level
// Splits requests into scan bytes and reads and stages read responses.
// ----------------------------------------------------------------------------
module scancode_set1_decoder_fifo_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scdf_req_if.sink  i_req,
    scdf_cfg_if.sink  i_cfg,
    scdf_rsp_if.source o_rsp
);
    import scdf_pkg::*;

    logic  req_fire;
    logic  byte_fire;
    logic  read_fire;
    logic  s1_adv;
    logic  q_empty;
    t_byte q_rd_data;
    t_push push;

    logic  r_s1_valid;
    logic  r_s1_empty;
    logic  r_out_valid;
    t_byte r_out_code;
    logic  r_out_empty;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign req_fire    = i_req.valid && i_req.ready;
    assign byte_fire   = req_fire && (i_req.req_type == ReqByte);
    assign read_fire   = req_fire && (i_req.req_type == ReqRead);

    scdf_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_byte_valid(byte_fire),
        .i_scan_byte (i_req.scan_byte),
        .o_push      (push)
    );

    scdf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rd_req (read_fire),
        .o_empty  (q_empty),
        .o_rd_data(q_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (read_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (read_fire) begin
            r_s1_empty <= q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_code  <= r_s1_empty ? '0 : q_rd_data;
            r_out_empty <= r_s1_empty;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.key_code    = r_out_code;
    assign o_rsp.queue_empty = r_out_empty;

endmodule
